@@ rtl/core/isw_pkg.sv @@
// Package for the interval stopwatch statistics unit: widths, event codes,
// queue entry, divider request/response and back-end state types.
// No dependencies.
package isw_pkg;

    localparam int TIME_W  = 48;
    localparam int COUNT_W = 32;
    localparam int SUM_W   = 64;

    // Divider iteration counter must hold SUM_W itself
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    // Queue between front and back end
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Event codes on the func field
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STOP  = 1'b1;

    // Classified event handed from front to back
    typedef struct packed {
        logic              measure;
        logic [TIME_W-1:0] delta;
    } isw_op_t;

    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [COUNT_W-1:0] divisor;
    } isw_div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } isw_div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_EMIT   = 4'b1000
    } isw_state_t;

endpackage

@@ rtl/core/isw_if.sv @@
// Channel interfaces of the interval stopwatch statistics unit.
// Depends on isw_pkg for field widths.
interface isw_evt_if;
    import isw_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [TIME_W-1:0] timestamp;

    modport source (output valid, output func, output timestamp, input ready);
    modport sink   (input valid, input func, input timestamp, output ready);
endinterface

interface isw_res_if;
    import isw_pkg::*;

    logic               valid;
    logic               ready;
    logic               measured;
    logic [TIME_W-1:0]  last_interval;
    logic [TIME_W-1:0]  interval_change;
    logic [TIME_W-1:0]  min_interval;
    logic [TIME_W-1:0]  max_interval;
    logic [TIME_W-1:0]  average_interval;
    logic [COUNT_W-1:0] sample_count;

    modport source (
        output valid, output measured, output last_interval, output interval_change,
        output min_interval, output max_interval, output average_interval,
        output sample_count, input ready
    );
    modport sink (
        input valid, input measured, input last_interval, input interval_change,
        input min_interval, input max_interval, input average_interval,
        input sample_count, output ready
    );
endinterface

@@ rtl/core/isw_front.sv @@
// Front end: accepts events, holds the start time and classifies each item
// into a measure or a no-op entry for the queue. Depends on isw_pkg, isw_if.
module isw_front (
    input  logic            clk,
    input  logic            rst_n,
    isw_evt_if.sink         events,
    input  logic            q_full,
    output logic            q_push,
    output isw_pkg::isw_op_t q_op
);
    import isw_pkg::*;

    logic [TIME_W-1:0] start_reg;

    assign events.ready = !q_full;
    assign q_push       = events.valid && !q_full;

    // A stop measures only while a nonzero start is held
    assign q_op.measure = (events.func == FUNC_STOP) && (start_reg != '0);
    assign q_op.delta   = events.timestamp - start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (q_push && (events.func == FUNC_START))
        begin
            start_reg <= events.timestamp;
        end
    end

endmodule

@@ rtl/core/isw_fifo.sv @@
// Short queue of classified items between front and back end.
// Depends on isw_pkg.
module isw_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  isw_pkg::isw_op_t push_op,
    input  logic             pop,
    output isw_pkg::isw_op_t head_op,
    output logic             full,
    output logic             empty
);
    import isw_pkg::*;

    isw_op_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign head_op = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

@@ rtl/core/isw_div.sv @@
// Restoring divider, one quotient bit per cycle, for the running average.
// Depends on isw_pkg.
module isw_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  isw_pkg::isw_div_req_t req,
    output isw_pkg::isw_div_rsp_t rsp
);
    import isw_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [COUNT_W:0]     rem_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [COUNT_W-1:0]   divisor_reg;

    logic [COUNT_W:0]     rem_sh;
    logic                 ge;
    logic [COUNT_W:0]     rem_next;
    logic [SUM_W-1:0]     quo_next;

    // Shift in the next dividend bit from the top of the quotient register
    always_comb
    begin
        rem_sh   = {rem_reg[COUNT_W-1:0], quo_reg[SUM_W-1]};
        ge       = (rem_sh >= {1'b0, divisor_reg});
        rem_next = ge ? (rem_sh - {1'b0, divisor_reg}) : rem_sh;
        quo_next = {quo_reg[SUM_W-2:0], ge};
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= DIV_CNT_W'(SUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/core/isw_back.sv @@
// Back end: pops classified items, updates the statistics, runs the average
// through the divider and holds the result register. Depends on isw_pkg, isw_if.
module isw_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  isw_pkg::isw_op_t      q_head,
    input  logic                  q_empty,
    output logic                  q_pop,
    output isw_pkg::isw_div_req_t div_req,
    input  isw_pkg::isw_div_rsp_t div_rsp,
    isw_res_if.source             results
);
    import isw_pkg::*;

    isw_state_t         state_reg;
    isw_state_t         state_next;

    logic [TIME_W-1:0]  delta_reg;
    logic               measured_reg;
    logic [TIME_W-1:0]  cur_reg;
    logic [TIME_W-1:0]  chg_reg;
    logic [TIME_W-1:0]  min_reg;
    logic [TIME_W-1:0]  max_reg;
    logic [SUM_W-1:0]   total_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [TIME_W-1:0]  mean_reg;

    logic [TIME_W-1:0]  chg_next;
    logic [SUM_W-1:0]   total_next;
    logic [COUNT_W-1:0] count_next;
    logic [TIME_W-1:0]  mean_next;
    logic [SUM_W:0]     total_sum;

    logic               out_valid_reg;
    logic               out_measured_reg;
    logic [TIME_W-1:0]  out_last_reg;
    logic [TIME_W-1:0]  out_chg_reg;
    logic [TIME_W-1:0]  out_min_reg;
    logic [TIME_W-1:0]  out_max_reg;
    logic [TIME_W-1:0]  out_avg_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               slot_free;

    assign slot_free = !out_valid_reg || results.ready;

    always_comb
    begin
        chg_next   = (cur_reg < delta_reg) ? (delta_reg - cur_reg) : (cur_reg - delta_reg);
        // Saturate the sum, hold the count at its maximum
        total_sum  = {1'b0, total_reg} + {{(SUM_W + 1 - TIME_W){1'b0}}, delta_reg};
        total_next = total_sum[SUM_W] ? '1 : total_sum[SUM_W-1:0];
        count_next = (count_reg != '1) ? (count_reg + 1'b1) : count_reg;
        mean_next  = (div_rsp.quotient[SUM_W-1:TIME_W] != '0) ? '1
                                                               : div_rsp.quotient[TIME_W-1:0];
    end

    always_comb
    begin
        state_next       = state_reg;
        q_pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = total_next;
        div_req.divisor  = count_next;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = q_head.measure ? ST_UPDATE : ST_EMIT;
                end
            end
            ST_UPDATE:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            measured_reg  <= 1'b0;
            cur_reg       <= '0;
            chg_reg       <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            mean_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                measured_reg <= q_head.measure;
            end
            if (state_reg == ST_UPDATE)
            begin
                chg_reg   <= chg_next;
                cur_reg   <= delta_reg;
                total_reg <= total_next;
                count_reg <= count_next;
                if (delta_reg < min_reg)
                begin
                    min_reg <= delta_reg;
                end
                if (delta_reg > max_reg)
                begin
                    max_reg <= delta_reg;
                end
            end
            if ((state_reg == ST_DIVIDE) && div_rsp.done)
            begin
                mean_reg <= mean_next;
            end
            if ((state_reg == ST_EMIT) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            delta_reg <= q_head.delta;
        end
        // Snapshot the statistics into the result register
        if ((state_reg == ST_EMIT) && slot_free)
        begin
            out_measured_reg <= measured_reg;
            out_last_reg     <= cur_reg;
            out_chg_reg      <= chg_reg;
            out_min_reg      <= min_reg;
            out_max_reg      <= max_reg;
            out_avg_reg      <= mean_reg;
            out_count_reg    <= count_reg;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.measured         = out_measured_reg;
    assign results.last_interval    = out_last_reg;
    assign results.interval_change  = out_chg_reg;
    assign results.min_interval     = out_min_reg;
    assign results.max_interval     = out_max_reg;
    assign results.average_interval = out_avg_reg;
    assign results.sample_count     = out_count_reg;

endmodule

@@ rtl/core/interval_stopwatch_statistics_unit.sv @@
// Channel   Dir  Handshake     Payload
// events    in   valid/ready   func, timestamp
// results   out  valid/ready   measured, last_interval, interval_change,
//                              min_interval, max_interval, average_interval,
//                              sample_count
//
// A start, or a stop that records nothing, goes from the queue straight to the
// result register. A measuring stop also waits for the bit-serial divider
// that forms the average; the back end handles one item at a time. A
// two-entry queue lets the front accept items while the back end divides;
// events.ready drops only on a full queue, which a held result can cause.
// Reset is asynchronous, active low, and clears all statistics at once.
// Top level of the interval stopwatch statistics unit.
// Depends on isw_pkg, isw_if, isw_front, isw_fifo, isw_div, isw_back.
module interval_stopwatch_statistics_unit (
    input  logic      clk,
    input  logic      rst_n,
    isw_evt_if.sink   events,
    isw_res_if.source results
);
    import isw_pkg::*;

    logic         q_push;
    logic         q_pop;
    logic         q_full;
    logic         q_empty;
    isw_op_t      push_op;
    isw_op_t      head_op;
    isw_div_req_t div_req;
    isw_div_rsp_t div_rsp;

    isw_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .events (events),
        .q_full (q_full),
        .q_push (q_push),
        .q_op   (push_op)
    );

    isw_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    isw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    isw_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (head_op),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .results (results)
    );

endmodule

@@ rtl/core/isw_checker.sv @@
// Port-level checks for the interval stopwatch statistics unit, bound to
// the top level. Depends on isw_pkg.
module isw_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic                        res_measured,
    input logic [isw_pkg::TIME_W-1:0]  res_last,
    input logic [isw_pkg::TIME_W-1:0]  res_min,
    input logic [isw_pkg::TIME_W-1:0]  res_max,
    input logic [isw_pkg::COUNT_W-1:0] res_count
);
    import isw_pkg::*;

    logic [COUNT_W-1:0] last_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
        end
        else if (res_valid && res_ready)
        begin
            last_count_reg <= res_count;
        end
    end

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> ($stable(res_count) && $stable(res_last)))
        else $error("result payload changed while stalled");

    a_interval_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_measured) |->
            ((res_min <= res_last) && (res_last <= res_max) && (res_count != '0)))
        else $error("measured interval outside min/max or zero count");

    a_count_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |-> (res_count >= last_count_reg))
        else $error("sample count decreased between items");

endmodule

bind interval_stopwatch_statistics_unit isw_checker u_isw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .res_measured (results.measured),
    .res_last     (results.last_interval),
    .res_min      (results.min_interval),
    .res_max      (results.max_interval),
    .res_count    (results.sample_count)
);
